// ----- sv/itb_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and microcode table of the interval timer bank
package itb_pkg;

	localparam int unsigned OPC_W   = 2;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned IVAL_W  = 32;
	localparam int unsigned ELAP_W  = 24;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CRED_W  = 32;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned PROD_W  = ELAP_W + SCALE_W;
	localparam int unsigned SCL_W   = PROD_W - FRAC_W;
	localparam int unsigned FCNT_W  = 5;

	// 1.0 in q8.8
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	// at most this many fire transactions per tick
	localparam logic [FCNT_W-1:0]  MAX_FIRES   = 5'd16;

	localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPC_W-1:0] OP_START  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CANCEL = 2'd2;
	localparam logic [OPC_W-1:0] OP_RESET  = 2'd3;

	localparam logic [KIND_W-1:0] EV_FIRED       = 2'd0;
	localparam logic [KIND_W-1:0] EV_DONE        = 2'd1;
	localparam logic [KIND_W-1:0] EV_ALREADY     = 2'd2;
	localparam logic [KIND_W-1:0] EV_NOT_RUNNING = 2'd3;

	typedef enum logic [3:0] {
		UC_IDLE,
		UC_MUL,
		UC_SCALE,
		UC_READ,
		UC_ADD,
		UC_WB,
		UC_NEXT,
		UC_DONE,
		UC_OP
	} step_t;

	typedef enum logic [2:0] {
		CD_SEQ,
		CD_ALWAYS,
		CD_NO_ACCEPT,
		CD_NOT_TICK,
		CD_NOT_RUNNING,
		CD_MORE
	} cond_t;

	typedef struct packed {
		step_t nxt;
		cond_t cond;
		logic  in_ready;
		logic  ld_mul;
		logic  ld_scale;
		logic  rd_mem;
		logic  ld_sum;
		logic  wb;
		logic  idx_inc;
		logic  emit_done;
		logic  do_op;
	} ucw_t;

	typedef struct packed {
		logic accept;
		logic not_tick;
		logic not_running;
		logic more;
		logic stall;
	} dp_stat_t;

	function automatic ucw_t ucode_rom(step_t s);
		ucw_t w;
		w = '0;
		w.nxt = UC_IDLE;
		w.cond = CD_SEQ;
		unique case (s)
			UC_IDLE: begin
				w.in_ready = 1'b1;
				w.cond = CD_NO_ACCEPT;
				w.nxt = UC_IDLE;
			end
			UC_MUL: begin
				w.ld_mul = 1'b1;
				w.cond = CD_NOT_TICK;
				w.nxt = UC_OP;
			end
			UC_SCALE: begin
				w.ld_scale = 1'b1;
			end
			UC_READ: begin
				w.rd_mem = 1'b1;
				w.cond = CD_NOT_RUNNING;
				w.nxt = UC_NEXT;
			end
			UC_ADD: begin
				w.ld_sum = 1'b1;
			end
			UC_WB: begin
				w.wb = 1'b1;
			end
			UC_NEXT: begin
				w.idx_inc = 1'b1;
				w.cond = CD_MORE;
				w.nxt = UC_READ;
			end
			UC_DONE: begin
				w.emit_done = 1'b1;
				w.cond = CD_ALWAYS;
				w.nxt = UC_IDLE;
			end
			UC_OP: begin
				w.do_op = 1'b1;
				w.cond = CD_ALWAYS;
				w.nxt = UC_IDLE;
			end
			default: begin
				w.cond = CD_ALWAYS;
				w.nxt = UC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- sv/itb_ifs.sv -----
`timescale 1ns / 1ps
// command and event channel interfaces of the interval timer bank
interface itb_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  timer_index;
	logic [31:0] interval_value;
	logic        auto_repeat;
	logic [23:0] elapsed_time;

	modport source (
		output valid, opcode, timer_index, interval_value, auto_repeat, elapsed_time,
		input  ready
	);
	modport sink (
		input  valid, opcode, timer_index, interval_value, auto_repeat, elapsed_time,
		output ready
	);
endinterface

interface itb_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [3:0]  fired_index;
	logic [31:0] credited_time;
	logic        last_of_run;

	modport source (
		output valid, event_kind, fired_index, credited_time, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, event_kind, fired_index, credited_time, last_of_run,
		output ready
	);
endinterface

// ----- sv/itb_sequencer.sv -----
`timescale 1ns / 1ps
// microcode step counter with conditional jumps
module itb_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  itb_pkg::dp_stat_t  st,
	output itb_pkg::ucw_t      cw
);

	itb_pkg::step_t upc_q;
	itb_pkg::step_t upc_d;
	itb_pkg::step_t upc_inc;

	// control word lookup
	always_comb begin
		cw = itb_pkg::ucode_rom(upc_q);
	end

	always_comb begin
		upc_inc = itb_pkg::step_t'(upc_q + 4'd1);
		upc_d = upc_q;
		if (!st.stall) begin
			unique case (cw.cond)
				itb_pkg::CD_SEQ:         upc_d = upc_inc;
				itb_pkg::CD_ALWAYS:      upc_d = cw.nxt;
				itb_pkg::CD_NO_ACCEPT:   upc_d = st.accept ? upc_inc : cw.nxt;
				itb_pkg::CD_NOT_TICK:    upc_d = st.not_tick ? cw.nxt : upc_inc;
				itb_pkg::CD_NOT_RUNNING: upc_d = st.not_running ? cw.nxt : upc_inc;
				itb_pkg::CD_MORE:        upc_d = st.more ? cw.nxt : upc_inc;
				default:                 upc_d = itb_pkg::UC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= itb_pkg::UC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ----- sv/itb_datapath.sv -----
`timescale 1ns / 1ps
// timer state, scaling multiplier, accumulate datapath and event register
module itb_datapath #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [itb_pkg::SCALE_W-1:0]         cfg_wdata,
	itb_cmd_if.sink                             cmd,
	itb_evt_if.source                           evt,
	input  itb_pkg::ucw_t                       cw,
	output itb_pkg::dp_stat_t                   st
);

	localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned TW = TIME_WIDTH;
	localparam int unsigned XW = IW + itb_pkg::IDX_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);
	localparam logic [XW-1:0] NUM_X = XW'(NUM_TIMERS);

	// configuration and captured command
	logic [itb_pkg::SCALE_W-1:0] scale_q;
	logic [itb_pkg::OPC_W-1:0]   op_q;
	logic [itb_pkg::IDX_W-1:0]   ti_q;
	logic [itb_pkg::IVAL_W-1:0]  ival_q;
	logic                        rep_q;
	logic [itb_pkg::ELAP_W-1:0]  el_q;

	// tick datapath
	logic [itb_pkg::PROD_W-1:0]  prod_q;
	logic [TW-1:0]               scaled_q;
	logic [IW-1:0]               idx_q;
	logic [itb_pkg::FCNT_W-1:0]  fcnt_q;
	logic [TW-1:0]               rd_acc_q;
	logic [TW-1:0]               rd_iv_q;
	logic                        rd_vld_q;
	logic [TW-1:0]               sum_q;
	logic                        fire_q;

	// per-timer state
	logic [NUM_TIMERS-1:0]       running_q;
	logic [NUM_TIMERS-1:0]       repeat_q;
	logic [NUM_TIMERS-1:0]       acc_vld_q;
	logic [TW-1:0]               acc_mem [NUM_TIMERS];
	logic [TW-1:0]               ival_mem [NUM_TIMERS];

	// event register
	logic                        out_vld_q;
	logic [itb_pkg::KIND_W-1:0]  kind_q;
	logic [itb_pkg::IDX_W-1:0]   oidx_q;
	logic [itb_pkg::CRED_W-1:0]  cred_q;
	logic                        last_q;

	logic                        accept;
	logic                        out_free;
	logic                        emit_fire;
	logic                        emit_req;
	logic                        stall;
	logic                        go;
	logic [XW-1:0]               ti_ext;
	logic [IW-1:0]               ti_idx;
	logic                        oor;
	logic [itb_pkg::SCL_W-1:0]   scl;
	logic [TW+itb_pkg::SCL_W-1:0] scl_ext;
	logic [TW-1:0]               scaled_d;
	logic [TW+itb_pkg::IVAL_W-1:0] iv_ext;
	logic [TW-1:0]               iv_trunc;
	logic [TW-1:0]               acc_cur;
	logic [TW:0]                 sum_w;
	logic [TW-1:0]               sum_d;
	logic [TW-1:0]               acc_wb;
	logic [TW-1:0]               credit_t;
	logic [TW+itb_pkg::CRED_W-1:0] cr_ext;
	logic [XW-1:0]               ix_ext;
	logic [itb_pkg::KIND_W-1:0]  op_kind;
	logic                        op_set_run;
	logic                        op_clr_run;
	logic                        op_clr_acc;
	logic [itb_pkg::KIND_W-1:0]  kind_d;
	logic [itb_pkg::IDX_W-1:0]   oidx_d;
	logic [itb_pkg::CRED_W-1:0]  cred_d;
	logic                        last_d;

	assign accept    = cmd.valid & cw.in_ready;
	assign cmd.ready = cw.in_ready;
	assign out_free  = ~out_vld_q | evt.ready;
	assign emit_fire = cw.wb & fire_q & (fcnt_q != itb_pkg::MAX_FIRES);
	assign emit_req  = emit_fire | cw.emit_done | cw.do_op;
	assign stall     = emit_req & ~out_free;
	assign go        = ~stall;

	assign ti_ext = {{IW{1'b0}}, ti_q};
	assign ti_idx = ti_ext[IW-1:0];
	assign oor    = ti_ext >= NUM_X;

	// q8.8 product drops its fraction, then saturates to the timer width
	assign scl      = prod_q[itb_pkg::PROD_W-1:itb_pkg::FRAC_W];
	assign scl_ext  = {{TW{1'b0}}, scl};
	assign scaled_d = (|scl_ext[TW+itb_pkg::SCL_W-1:TW]) ? {TW{1'b1}} : scl_ext[TW-1:0];

	assign iv_ext   = {{TW{1'b0}}, ival_q};
	assign iv_trunc = iv_ext[TW-1:0];

	// never written accumulators read as zero
	assign acc_cur = rd_vld_q ? rd_acc_q : '0;
	assign sum_w   = {1'b0, acc_cur} + {1'b0, scaled_q};
	assign sum_d   = sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0];

	assign acc_wb   = (fire_q & repeat_q[idx_q]) ? (sum_q - rd_iv_q) : sum_q;
	assign credit_t = (rd_iv_q == '0) ? scaled_q : rd_iv_q;
	assign cr_ext   = {{itb_pkg::CRED_W{1'b0}}, credit_t};
	assign ix_ext   = {{itb_pkg::IDX_W{1'b0}}, idx_q};

	assign st.accept      = accept;
	assign st.not_tick    = op_q != itb_pkg::OP_TICK;
	assign st.not_running = ~running_q[idx_q];
	assign st.more        = idx_q != LAST_IDX;
	assign st.stall       = stall;

	// start, cancel and reset decode
	always_comb begin
		op_kind    = itb_pkg::EV_DONE;
		op_set_run = 1'b0;
		op_clr_run = 1'b0;
		op_clr_acc = 1'b0;
		if (oor) begin
			op_kind = itb_pkg::EV_NOT_RUNNING;
		end else begin
			unique case (op_q)
				itb_pkg::OP_START: begin
					if (running_q[ti_idx]) begin
						op_kind = itb_pkg::EV_ALREADY;
					end else begin
						op_set_run = 1'b1;
					end
				end
				itb_pkg::OP_CANCEL: begin
					if (!running_q[ti_idx]) begin
						op_kind = itb_pkg::EV_NOT_RUNNING;
					end else begin
						op_clr_run = 1'b1;
					end
				end
				itb_pkg::OP_RESET: begin
					op_clr_run = 1'b1;
					op_clr_acc = 1'b1;
				end
				itb_pkg::OP_TICK: begin
					op_kind = itb_pkg::EV_DONE;
				end
				default: begin
					op_kind = itb_pkg::EV_DONE;
				end
			endcase
		end
	end

	always_comb begin
		kind_d = itb_pkg::EV_DONE;
		oidx_d = '0;
		cred_d = '0;
		last_d = 1'b1;
		priority if (emit_fire) begin
			kind_d = itb_pkg::EV_FIRED;
			oidx_d = ix_ext[itb_pkg::IDX_W-1:0];
			cred_d = cr_ext[itb_pkg::CRED_W-1:0];
			last_d = 1'b0;
		end else if (cw.do_op) begin
			kind_d = op_kind;
			oidx_d = ti_q;
		end else begin
			kind_d = itb_pkg::EV_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= itb_pkg::SCALE_RESET;
			running_q <= '0;
			repeat_q  <= '0;
			acc_vld_q <= '0;
			out_vld_q <= 1'b0;
			idx_q     <= '0;
			fcnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (cw.ld_mul) begin
				idx_q  <= '0;
				fcnt_q <= '0;
			end
			if (cw.idx_inc && go && st.more) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit_fire && go) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (cw.wb && go) begin
				acc_vld_q[idx_q] <= 1'b1;
				if (fire_q && !repeat_q[idx_q]) begin
					running_q[idx_q] <= 1'b0;
				end
			end
			if (cw.do_op && go) begin
				if (op_set_run) begin
					running_q[ti_idx] <= 1'b1;
					repeat_q[ti_idx]  <= rep_q;
				end
				if (op_clr_run) begin
					running_q[ti_idx] <= 1'b0;
				end
				if (op_clr_acc) begin
					acc_vld_q[ti_idx] <= 1'b0;
				end
			end
			if (out_vld_q && evt.ready) begin
				out_vld_q <= 1'b0;
			end
			if (emit_req && go) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.opcode;
			ti_q   <= cmd.timer_index;
			ival_q <= cmd.interval_value;
			rep_q  <= cmd.auto_repeat;
			el_q   <= cmd.elapsed_time;
		end
		if (cw.ld_mul) begin
			prod_q <= itb_pkg::PROD_W'(el_q) * itb_pkg::PROD_W'(scale_q);
		end
		if (cw.ld_scale) begin
			scaled_q <= scaled_d;
		end
		if (cw.rd_mem) begin
			rd_acc_q <= acc_mem[idx_q];
			rd_iv_q  <= ival_mem[idx_q];
			rd_vld_q <= acc_vld_q[idx_q];
		end
		if (cw.ld_sum) begin
			sum_q  <= sum_d;
			fire_q <= sum_d >= rd_iv_q;
		end
		if (cw.wb && go) begin
			acc_mem[idx_q] <= acc_wb;
		end
		if (cw.do_op && go && op_set_run) begin
			ival_mem[ti_idx] <= iv_trunc;
		end
		if (emit_req && go) begin
			kind_q <= kind_d;
			oidx_q <= oidx_d;
			cred_q <= cred_d;
			last_q <= last_d;
		end
	end

	assign evt.valid         = out_vld_q;
	assign evt.event_kind    = kind_q;
	assign evt.fired_index   = oidx_q;
	assign evt.credited_time = cred_q;
	assign evt.last_of_run   = last_q;

endmodule

// ----- sv/interval_timer_bank_core.sv -----
`timescale 1ns / 1ps
// top level of the interval timer bank: microcode sequencer and timer datapath
//
//   channel   direction  handshake            payload
//   cmd       in         cmd.valid/cmd.ready  opcode, timer_index, interval_value,
//                                             auto_repeat, elapsed_time
//   evt       out        evt.valid/evt.ready  event_kind, fired_index,
//                                             credited_time, last_of_run
//   cfg       in         cfg_we               cfg_wdata (time_scale, q8.8)
//
// start, cancel and reset pass the multiply step, then load the event register in the op step.
// a tick steps through multiply and scale, then read and next per stopped timer, or read, add,
// write-back and next per running timer on the one accumulator memory port, and ends in done.
// a full event register stalls the sequencer on the step that emits.
// reset takes effect at once: valid bits stand for the zeroed accumulators.
module interval_timer_bank_core #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [itb_pkg::SCALE_W-1:0] cfg_wdata,
	itb_cmd_if.sink                     cmd,
	itb_evt_if.source                   evt
);

	itb_pkg::ucw_t     cw;
	itb_pkg::dp_stat_t st;

	itb_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw)
	);

	itb_datapath #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.evt       (evt),
		.cw        (cw),
		.st        (st)
	);

endmodule

// ----- sv/itb_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the interval timer bank, bound to the top level
module itb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic [1:0]  evt_kind,
	input logic [31:0] evt_credit,
	input logic        evt_last
);

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("event transaction dropped while stalled");

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_kind == itb_pkg::EV_FIRED |-> !evt_last)
		else $error("fire transaction marked last");

	a_other_closes: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_kind != itb_pkg::EV_FIRED |-> evt_last && evt_credit == 32'd0)
		else $error("status transaction not last or carries credit");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in flight");

endmodule

bind interval_timer_bank_core itb_checker u_itb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.evt_valid  (evt.valid),
	.evt_ready  (evt.ready),
	.evt_kind   (evt.event_kind),
	.evt_credit (evt.credited_time),
	.evt_last   (evt.last_of_run)
);

// ----- test/tb_interval_timer_bank_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the interval timer bank core with a built-in timer predictor
module tb_interval_timer_bank_core;

	localparam int unsigned NUM_TIMERS    = 16;
	localparam int unsigned MAX_GAP       = 9;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned END_CYCLES    = 100;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_ITEMS   = 48;
	localparam int unsigned NUM_PHASES    = 5;

	typedef struct packed {
		logic [itb_pkg::OPC_W-1:0]  opcode;
		logic [itb_pkg::IDX_W-1:0]  timer_index;
		logic [itb_pkg::IVAL_W-1:0] interval_value;
		logic                       auto_repeat;
		logic [itb_pkg::ELAP_W-1:0] elapsed_time;
	} timer_cmd_t;

	typedef struct packed {
		logic [itb_pkg::KIND_W-1:0] kind;
		logic [itb_pkg::IDX_W-1:0]  idx;
		logic [itb_pkg::CRED_W-1:0] credit;
		logic                       last_of_run;
	} timer_event_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [itb_pkg::SCALE_W-1:0]  cfg_wdata;

	itb_cmd_if cmd_ch();
	itb_evt_if evt_ch();

	interval_timer_bank_core #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_ch),
		.evt(evt_ch)
	);

	// predicted timer state
	logic [itb_pkg::SCALE_W-1:0] model_scale;
	logic               running_q  [NUM_TIMERS];
	logic               repeat_q   [NUM_TIMERS];
	logic [31:0]        interval_q [NUM_TIMERS];
	logic [31:0]        accum_q    [NUM_TIMERS];

	timer_cmd_t   cmd_backlog[$];
	timer_event_t expected_events[$];
	int unsigned  mismatch_count;

	timer_cmd_t  cmd_next;
	bit          cmd_offering;
	bit          cmd_taken;
	bit          cmd_gaps_on;
	int unsigned cmd_gap;
	int unsigned cmd_mode_left;

	bit          evt_taken;
	bit          evt_gaps_on;
	bit          evt_open;
	int unsigned evt_gap;
	int unsigned evt_mode_left;
	int unsigned evt_hold;

	int unsigned quiet_cycles;

	function automatic timer_event_t make_event(logic [itb_pkg::KIND_W-1:0] kind,
			logic [itb_pkg::IDX_W-1:0] idx, logic [itb_pkg::CRED_W-1:0] credit,
			logic last_of_run);
		timer_event_t e;
		e.kind = kind;
		e.idx = idx;
		e.credit = credit;
		e.last_of_run = last_of_run;
		return e;
	endfunction

	function automatic void add_expected(logic [itb_pkg::KIND_W-1:0] kind,
			logic [itb_pkg::IDX_W-1:0] idx, logic [itb_pkg::CRED_W-1:0] credit,
			logic last_of_run);
		expected_events = {expected_events, make_event(kind, idx, credit, last_of_run)};
	endfunction

	function automatic void predict_timer_events(timer_cmd_t c);
		logic [itb_pkg::PROD_W-1:0] product;
		logic [31:0]       scaled;
		logic [32:0]       sum;
		if (c.opcode == itb_pkg::OP_TICK) begin
			product = itb_pkg::PROD_W'(c.elapsed_time) * itb_pkg::PROD_W'(model_scale);
			scaled = product[itb_pkg::PROD_W-1:itb_pkg::FRAC_W];
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (running_q[i]) begin
					sum = {1'b0, accum_q[i]} + {1'b0, scaled};
					accum_q[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (accum_q[i] >= interval_q[i]) begin
						add_expected(itb_pkg::EV_FIRED, 4'(i),
							(interval_q[i] == 32'd0) ? scaled : interval_q[i], 1'b0);
						if (repeat_q[i])
							accum_q[i] -= interval_q[i];
						else
							running_q[i] = 1'b0;
					end
				end
			end
			add_expected(itb_pkg::EV_DONE, '0, '0, 1'b1);
		end else if (c.opcode == itb_pkg::OP_START) begin
			if (running_q[c.timer_index]) begin
				add_expected(itb_pkg::EV_ALREADY, c.timer_index, '0, 1'b1);
			end else begin
				// accumulator is left as it was
				running_q[c.timer_index] = 1'b1;
				repeat_q[c.timer_index] = c.auto_repeat;
				interval_q[c.timer_index] = c.interval_value;
				add_expected(itb_pkg::EV_DONE, c.timer_index, '0, 1'b1);
			end
		end else if (c.opcode == itb_pkg::OP_CANCEL) begin
			if (!running_q[c.timer_index]) begin
				add_expected(itb_pkg::EV_NOT_RUNNING, c.timer_index, '0, 1'b1);
			end else begin
				running_q[c.timer_index] = 1'b0;
				add_expected(itb_pkg::EV_DONE, c.timer_index, '0, 1'b1);
			end
		end else begin
			running_q[c.timer_index] = 1'b0;
			accum_q[c.timer_index] = '0;
			add_expected(itb_pkg::EV_DONE, c.timer_index, '0, 1'b1);
		end
	endfunction

	function automatic void queue_cmd(logic [itb_pkg::OPC_W-1:0] opcode,
			logic [itb_pkg::IDX_W-1:0] idx, logic [itb_pkg::IVAL_W-1:0] ival, logic rep,
			logic [itb_pkg::ELAP_W-1:0] el);
		timer_cmd_t c;
		c.opcode = opcode;
		c.timer_index = idx;
		c.interval_value = ival;
		c.auto_repeat = rep;
		c.elapsed_time = el;
		cmd_backlog = {cmd_backlog, c};
	endfunction

	function automatic void queue_random_cmds(int unsigned count);
		int unsigned made;
		int unsigned pick;
		int unsigned first;
		int unsigned span;
		logic [itb_pkg::IVAL_W-1:0] ival;
		logic [itb_pkg::ELAP_W-1:0] el;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 9))
				0, 1: ival = '0;
				2: ival = $urandom;
				3: ival = $urandom_range(1, 20000);
				default: ival = $urandom_range(1, 600);
			endcase
			case ($urandom_range(0, 9))
				0: el = itb_pkg::ELAP_W'($urandom);
				1, 2: el = itb_pkg::ELAP_W'($urandom_range(0, 4000));
				default: el = itb_pkg::ELAP_W'($urandom_range(0, 400));
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// arm a run of timers then tick, to get long fire trains
				first = $urandom_range(0, NUM_TIMERS - 1);
				span = $urandom_range(4, NUM_TIMERS);
				for (int k = 0; k < span; k++)
					queue_cmd(itb_pkg::OP_START, 4'((first + k) % NUM_TIMERS),
						($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom_range(1, 50)),
						1'($urandom_range(0, 1)), itb_pkg::ELAP_W'($urandom));
				queue_cmd(itb_pkg::OP_TICK, 4'($urandom), $urandom,
					1'($urandom_range(0, 1)), el);
				made += span + 1;
			end else begin
				if (pick < 38)
					queue_cmd(itb_pkg::OP_TICK, 4'($urandom), $urandom,
						1'($urandom_range(0, 1)), el);
				else if (pick < 72)
					queue_cmd(itb_pkg::OP_START, 4'($urandom), ival,
						1'($urandom_range(0, 1)), el);
				else if (pick < 86)
					queue_cmd(itb_pkg::OP_CANCEL, 4'($urandom), ival,
						1'($urandom_range(0, 1)), el);
				else
					queue_cmd(itb_pkg::OP_RESET, 4'($urandom), ival,
						1'($urandom_range(0, 1)), el);
				made++;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic wait_for_drain(input int unsigned settle);
		while (cmd_backlog.size() != 0 || cmd_offering || expected_events.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_time_scale(input logic [itb_pkg::SCALE_W-1:0] value);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_scale = value;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken) begin
				cmd_taken = 1'b0;
				cmd_offering = 1'b0;
				if (cmd_mode_left == 0) begin
					cmd_gaps_on = ($urandom_range(0, 2) != 0);
					cmd_mode_left = $urandom_range(5, 30);
				end
				cmd_mode_left--;
				cmd_gap = cmd_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (!cmd_offering) begin
				if (cmd_gap != 0) begin
					cmd_gap--;
				end else if (cmd_backlog.size() != 0) begin
					cmd_next = cmd_backlog.pop_front();
					cmd_offering = 1'b1;
					cmd_ch.opcode <= cmd_next.opcode;
					cmd_ch.timer_index <= cmd_next.timer_index;
					cmd_ch.interval_value <= cmd_next.interval_value;
					cmd_ch.auto_repeat <= cmd_next.auto_repeat;
					cmd_ch.elapsed_time <= cmd_next.elapsed_time;
				end
			end
			cmd_ch.valid <= cmd_offering;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			predict_timer_events(cmd_next);
			cmd_taken = 1'b1;
		end
	end

	// event receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (evt_taken) begin
				evt_taken = 1'b0;
				if (evt_mode_left == 0) begin
					evt_gaps_on = ($urandom_range(0, 2) != 0);
					evt_mode_left = $urandom_range(5, 30);
				end
				evt_mode_left--;
				evt_gap = evt_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (evt_hold != 0) begin
				evt_hold--;
				evt_open = 1'b0;
			end else if (evt_gap != 0) begin
				evt_gap--;
				evt_open = 1'b0;
			end else begin
				evt_open = 1'b1;
			end
			evt_ch.ready <= evt_open;
		end
	end

	always @(posedge clk) begin : check_events
		timer_event_t seen;
		timer_event_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			evt_taken = 1'b1;
			seen = make_event(evt_ch.event_kind, evt_ch.fired_index, evt_ch.credited_time,
				evt_ch.last_of_run);
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d timer %0d",
					seen.kind, seen.idx));
			end else begin
				want = expected_events.pop_front();
				if (seen.kind !== want.kind)
					report_mismatch($sformatf("event_kind got %0d want %0d",
						seen.kind, want.kind));
				if (seen.idx !== want.idx)
					report_mismatch($sformatf("fired_index got %0d want %0d",
						seen.idx, want.idx));
				if (seen.credit !== want.credit)
					report_mismatch($sformatf("credited_time got %0h want %0h (timer %0d)",
						seen.credit, want.credit, want.idx));
				if (seen.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run got %0d want %0d (timer %0d)",
						seen.last_of_run, want.last_of_run, want.idx));
			end
		end
	end

	// no transaction on either channel for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL interval_timer_bank_core");
				$finish;
			end
		end
	end

	initial begin
		logic [itb_pkg::SCALE_W-1:0] phase_scale [NUM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = '0;
		cmd_ch.timer_index = '0;
		cmd_ch.interval_value = '0;
		cmd_ch.auto_repeat = 1'b0;
		cmd_ch.elapsed_time = '0;
		evt_ch.ready = 1'b0;
		model_scale = itb_pkg::SCALE_RESET;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			running_q[i] = 1'b0;
			repeat_q[i] = 1'b0;
			interval_q[i] = '0;
			accum_q[i] = '0;
		end
		mismatch_count = 0;
		cmd_offering = 1'b0;
		cmd_taken = 1'b0;
		cmd_gap = 0;
		cmd_mode_left = 0;
		evt_taken = 1'b0;
		evt_gap = 0;
		evt_mode_left = 0;
		evt_hold = 0;
		quiet_cycles = 0;
		phase_scale = '{16'd0, 16'd1, 16'($urandom_range(2, 65534)), 16'd128, 16'hFFFF};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed part at the reset scale of 1.0
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'd0);
		queue_cmd(itb_pkg::OP_START, 4'd0, 32'd100, 1'b1, '0);
		queue_cmd(itb_pkg::OP_START, 4'd0, 32'd5, 1'b0, '0);
		queue_cmd(itb_pkg::OP_CANCEL, 4'd5, '0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_START, 4'd15, 32'd0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_START, 4'd3, 32'd0, 1'b1, '0);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'd250);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'd0);
		queue_cmd(itb_pkg::OP_CANCEL, 4'd0, '0, 1'b0, '0);
		// restart keeps the leftover accumulator
		queue_cmd(itb_pkg::OP_START, 4'd0, 32'd60, 1'b0, '0);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'd10);
		queue_cmd(itb_pkg::OP_RESET, 4'd3, '0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_RESET, 4'd9, '0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_CANCEL, 4'd3, '0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_START, 4'd7, 32'hFFFF_FFFF, 1'b1, '0);
		queue_cmd(itb_pkg::OP_START, 4'd8, 32'hFFFF_FFFF, 1'b0, '0);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'hFF_FFFF);
		wait_for_drain(SETTLE_CYCLES);

		// largest scale: accumulators saturate
		write_time_scale(16'hFFFF);
		queue_cmd(itb_pkg::OP_START, 4'd3, 32'd0, 1'b1, '0);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'hFF_FFFF);
		queue_cmd(itb_pkg::OP_TICK, 4'd0, '0, 1'b0, 24'hFF_FFFF);
		queue_cmd(itb_pkg::OP_RESET, 4'd7, '0, 1'b0, '0);
		queue_cmd(itb_pkg::OP_CANCEL, 4'd8, '0, 1'b0, '0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_for_drain(SETTLE_CYCLES);
			write_time_scale(phase_scale[p]);
			// event side backs up while commands keep coming
			if (p == 2)
				evt_hold = HOLD_CYCLES;
			queue_random_cmds(PHASE_ITEMS);
		end

		wait_for_drain(END_CYCLES);
		if (mismatch_count == 0)
			$display("PASS interval_timer_bank_core");
		else
			$display("FAIL interval_timer_bank_core");
		$finish;
	end

endmodule

// ----- files.f -----
sv/itb_pkg.sv
sv/itb_ifs.sv
sv/itb_sequencer.sv
sv/itb_datapath.sv
sv/interval_timer_bank_core.sv
sv/itb_checker.sv
test/tb_interval_timer_bank_core.sv
